/* rtl/msps_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// msps_pkg
// Shared types, sizes and constants of the multi-servo pulse sequencer.
// ----------------------------------------------------------------------------
package msps_pkg;

  localparam int NUM_SLOTS  = 8;
  localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int SCAN_W     = $clog2(NUM_SLOTS + 1);

  localparam int TPM_W      = 15;
  localparam int PIN_W      = 8;
  localparam int TICKS_W    = 16;
  localparam int US_W       = 16;
  localparam int SID_W      = 3;
  localparam int REQ_SLOT_W = 3;

  localparam logic [TPM_W-1:0] TPM_RESET = 15'd2000;

  localparam int FRAME_MS   = 20;
  localparam int US_PER_MS  = 1000;
  localparam int CENTER_NUM = 3;
  localparam int CENTER_DEN = 2;

  // frame time never exceeds 20 * 32767 plus one 16-bit interval
  localparam int ELAPSED_W  = 20;

  // microseconds to ticks: product, pre-shift, reciprocal multiply
  localparam int PROD_W      = US_W + TPM_W;
  localparam longint SAT_LIMIT = 65536 * US_PER_MS;
  localparam int SAT_W       = 26;
  localparam int PRE_SHIFT   = 3;
  localparam int RECIP_DIV   = US_PER_MS / 8;
  localparam int RECIP_N_W   = SAT_W - PRE_SHIFT;
  localparam int RECIP_SHIFT = 30;
  localparam int RECIP_MUL_W = 24;
  localparam longint RECIP_MUL =
    ((longint'(1) << RECIP_SHIFT) + RECIP_DIV - 1) / RECIP_DIV;
  localparam int RECIP_P_W   = RECIP_N_W + RECIP_MUL_W;

  typedef enum logic [1:0] {
    REQ_COMPARE = 2'd0,
    REQ_ADD     = 2'd1,
    REQ_DELETE  = 2'd2,
    REQ_SET     = 2'd3
  } req_type_e;

  typedef struct packed {
    req_type_e             req_type;
    logic [REQ_SLOT_W-1:0] slot;
    logic [PIN_W-1:0]      pin;
    logic [US_W-1:0]       pulse_us;
  } req_t;

  typedef struct packed {
    logic               clear_valid;
    logic [PIN_W-1:0]   clear_pin;
    logic               set_valid;
    logic [PIN_W-1:0]   set_pin;
    logic [TICKS_W-1:0] next_interval;
    logic               add_ok;
    logic [SID_W-1:0]   slot_id;
  } res_t;

  typedef struct packed {
    logic [PIN_W-1:0]   pin;
    logic [TICKS_W-1:0] ticks;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic [SLOT_W-1:0] req_slot_idx(input logic [REQ_SLOT_W-1:0] s);
    logic [SLOT_W+REQ_SLOT_W-1:0] w;
    w = {{SLOT_W{1'b0}}, s};
    return w[SLOT_W-1:0];
  endfunction

  function automatic logic [SID_W-1:0] to_slot_id(input logic [SLOT_W-1:0] s);
    logic [SLOT_W+SID_W-1:0] w;
    w = {{SID_W{1'b0}}, s};
    return w[SID_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/msps_slot_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// msps_slot_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module msps_slot_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 24
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                           wdata_i,
  input  wire logic                                       re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output      logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // hold the last read until the next one
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* rtl/msps_tick_conv.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// msps_tick_conv
// Two-stage pipeline: pulse_us * ticks_per_ms / 1000, saturated at 16 bits.
// ----------------------------------------------------------------------------
module msps_tick_conv (
  input  wire logic                          clk_i,
  input  wire logic [msps_pkg::US_W-1:0]     us_i,
  input  wire logic [msps_pkg::TPM_W-1:0]    tpm_i,
  output      logic [msps_pkg::TICKS_W-1:0]  ticks_o
);

  logic [msps_pkg::PROD_W-1:0]    prod_q;
  logic                           sat_q;
  logic [msps_pkg::RECIP_P_W-1:0] recip_q;

  // divide by 8 first, then by 125 through a reciprocal that is exact below the limit
  always_ff @(posedge clk_i) begin
    prod_q  <= msps_pkg::PROD_W'(us_i) * msps_pkg::PROD_W'(tpm_i);
    sat_q   <= (prod_q >= msps_pkg::PROD_W'(msps_pkg::SAT_LIMIT));
    recip_q <= msps_pkg::RECIP_P_W'(prod_q[msps_pkg::SAT_W-1:msps_pkg::PRE_SHIFT])
             * msps_pkg::RECIP_P_W'(msps_pkg::RECIP_MUL);
  end

  assign ticks_o = sat_q ? {msps_pkg::TICKS_W{1'b1}}
                         : recip_q[msps_pkg::RECIP_SHIFT +: msps_pkg::TICKS_W];

endmodule
`default_nettype wire

/* rtl/msps_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// msps_ctrl
// Request sequencer: slot flags, frame state, slot RAM access and conversion.
// ----------------------------------------------------------------------------
module msps_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [msps_pkg::TPM_W-1:0]  cfg_wdata_i,
  input  wire logic                        req_valid_i,
  input  wire msps_pkg::req_t              req_i,
  output      logic                        req_ready_o,
  output      logic                        res_valid_o,
  output      msps_pkg::res_t              res_o,
  input  wire logic                        res_ready_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_CMP0, S_CMP1, S_SCAN, S_FETCH, S_ADD, S_DEL,
    S_SET0, S_SET1, S_SET2, S_DONE
  } state_e;

  state_e                             state_q;
  msps_pkg::req_t                     req_q;
  msps_pkg::res_t                     res_q;
  logic [msps_pkg::TPM_W-1:0]         tpm_q;
  logic [msps_pkg::NUM_SLOTS-1:0]     used_q;
  logic [msps_pkg::ELAPSED_W-1:0]     elapsed_q;
  logic [msps_pkg::SCAN_W-1:0]        scan_q;
  logic [msps_pkg::SCAN_W-1:0]        srch_q;
  logic [msps_pkg::SLOT_W-1:0]        prev_q;
  logic                               prev_active_q;

  logic                               ram_we;
  logic [msps_pkg::SLOT_W-1:0]        ram_waddr;
  msps_pkg::entry_t                   ram_wdata;
  logic                               ram_re;
  logic [msps_pkg::SLOT_W-1:0]        ram_raddr;
  msps_pkg::entry_t                   ram_rdata;
  logic [msps_pkg::TICKS_W-1:0]       conv_ticks;

  logic [msps_pkg::ELAPSED_W-1:0]     thresh;
  logic [msps_pkg::TICKS_W-1:0]       center_ticks;
  logic [msps_pkg::SLOT_W-1:0]        req_idx;
  logic                               req_hit;
  logic [msps_pkg::SLOT_W-1:0]        scan_idx;
  logic                               scan_in;
  logic [msps_pkg::SLOT_W-1:0]        srch_idx;
  logic                               srch_in;

  assign thresh       = msps_pkg::ELAPSED_W'(tpm_q) * msps_pkg::ELAPSED_W'(msps_pkg::FRAME_MS);
  assign center_ticks = msps_pkg::TICKS_W'(
                          (17'(tpm_q) * 17'(msps_pkg::CENTER_NUM)) / msps_pkg::CENTER_DEN);
  assign req_idx      = msps_pkg::req_slot_idx(req_q.slot);
  assign req_hit      = (32'(req_q.slot) < msps_pkg::NUM_SLOTS) && used_q[req_idx];
  assign scan_idx     = scan_q[msps_pkg::SLOT_W-1:0];
  assign scan_in      = (32'(scan_q) < msps_pkg::NUM_SLOTS);
  assign srch_idx     = srch_q[msps_pkg::SLOT_W-1:0];
  assign srch_in      = (32'(srch_q) < msps_pkg::NUM_SLOTS);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = srch_idx;
    ram_wdata = '{pin: req_q.pin, ticks: center_ticks};
    ram_re    = 1'b0;
    ram_raddr = prev_q;
    case (state_q)
      S_CMP0: begin
        ram_re = 1'b1;
      end
      S_SCAN: begin
        ram_re    = scan_in && used_q[scan_idx];
        ram_raddr = scan_idx;
      end
      S_SET0: begin
        ram_re    = 1'b1;
        ram_raddr = req_idx;
      end
      S_ADD: begin
        ram_we = srch_in && !used_q[srch_idx];
      end
      S_SET2: begin
        // keep the pin, replace the ticks
        ram_we    = req_hit;
        ram_waddr = req_idx;
        ram_wdata = '{pin: ram_rdata.pin, ticks: conv_ticks};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      tpm_q         <= msps_pkg::TPM_RESET;
      used_q        <= '0;
      elapsed_q     <= '0;
      scan_q        <= '0;
      srch_q        <= '0;
      prev_q        <= '0;
      prev_active_q <= 1'b0;
      req_q         <= '0;
      res_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        tpm_q <= cfg_wdata_i;
      end
      case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            req_q  <= req_i;
            res_q  <= '0;
            srch_q <= '0;
            case (req_i.req_type)
              msps_pkg::REQ_COMPARE: state_q <= S_CMP0;
              msps_pkg::REQ_ADD:     state_q <= S_ADD;
              msps_pkg::REQ_DELETE:  state_q <= S_DEL;
              msps_pkg::REQ_SET:     state_q <= S_SET0;
              default:               state_q <= S_IDLE;
            endcase
          end
        end
        S_CMP0: begin
          // restart the frame once it has run past 20 ms
          if (elapsed_q > thresh) begin
            elapsed_q <= '0;
            scan_q    <= '0;
          end
          res_q.clear_valid <= prev_active_q && used_q[prev_q];
          state_q <= S_CMP1;
        end
        S_CMP1: begin
          if (res_q.clear_valid) begin
            res_q.clear_pin <= ram_rdata.pin;
          end
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (!scan_in) begin
            prev_active_q       <= 1'b0;
            res_q.next_interval <= msps_pkg::TICKS_W'(tpm_q);
            elapsed_q           <= elapsed_q + msps_pkg::ELAPSED_W'(tpm_q);
            state_q             <= S_DONE;
          end else if (used_q[scan_idx]) begin
            state_q <= S_FETCH;
          end else begin
            scan_q <= scan_q + 1'b1;
          end
        end
        S_FETCH: begin
          res_q.set_valid     <= 1'b1;
          res_q.set_pin       <= ram_rdata.pin;
          res_q.next_interval <= ram_rdata.ticks;
          elapsed_q           <= elapsed_q + msps_pkg::ELAPSED_W'(ram_rdata.ticks);
          prev_q              <= scan_idx;
          prev_active_q       <= 1'b1;
          scan_q              <= scan_q + 1'b1;
          state_q             <= S_DONE;
        end
        S_ADD: begin
          if (!srch_in) begin
            state_q <= S_DONE;
          end else if (!used_q[srch_idx]) begin
            used_q[srch_idx] <= 1'b1;
            res_q.add_ok     <= 1'b1;
            res_q.slot_id    <= msps_pkg::to_slot_id(srch_idx);
            state_q          <= S_DONE;
          end else begin
            srch_q <= srch_q + 1'b1;
          end
        end
        S_DEL: begin
          if (req_hit) begin
            used_q[req_idx] <= 1'b0;
          end
          state_q <= S_DONE;
        end
        S_SET0: state_q <= S_SET1;
        S_SET1: state_q <= S_SET2;
        S_SET2: state_q <= S_DONE;
        S_DONE: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

  msps_slot_ram #(
    .DEPTH (msps_pkg::NUM_SLOTS),
    .WIDTH (msps_pkg::ENTRY_W)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  msps_tick_conv u_tick_conv (
    .clk_i   (clk_i),
    .us_i    (req_q.pulse_us),
    .tpm_i   (tpm_q),
    .ticks_o (conv_ticks)
  );

endmodule
`default_nettype wire

/* rtl/multi_servo_pulse_sequencer_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// multi_servo_pulse_sequencer_top
// Time-multiplexed RC servo pulse sequencer with a 20 ms frame.
// ----------------------------------------------------------------------------
// Every request gives exactly one result. Requests are handled one at a time;
// a result waits in the output register while the next request is taken in.
// A compare event steps over the free slots to the next used one, or runs
// past the last slot. The slot flags are walked one per cycle and the slot RAM
// has a single read port, so the previous pin and the next entry are read one
// after the other. An add passes over the used slots to the first free one,
// and a set goes through the two-stage microsecond-to-tick multiplier and
// the RAM read-modify-write. Pin and tick entries of a slot are only valid
// once an add has written them; no clearing pass runs after reset.
module multi_servo_pulse_sequencer_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [msps_pkg::TPM_W-1:0]    cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic [1:0]                    req_type_i,
  input  wire logic [msps_pkg::REQ_SLOT_W-1:0] slot_i,
  input  wire logic [msps_pkg::PIN_W-1:0]    pin_i,
  input  wire logic [msps_pkg::US_W-1:0]     pulse_us_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic                          clear_valid_o,
  output      logic [msps_pkg::PIN_W-1:0]    clear_pin_o,
  output      logic                          set_valid_o,
  output      logic [msps_pkg::PIN_W-1:0]    set_pin_o,
  output      logic [msps_pkg::TICKS_W-1:0]  next_interval_o,
  output      logic                          add_ok_o,
  output      logic [msps_pkg::SID_W-1:0]    slot_id_o
);

  msps_pkg::req_t req;
  msps_pkg::res_t res;
  msps_pkg::res_t out_q;
  logic           out_valid_q;
  logic           res_valid;
  logic           res_ready;

  assign req = '{req_type: msps_pkg::req_type_e'(req_type_i), slot: slot_i,
                 pin: pin_i, pulse_us: pulse_us_i};

  // take a new result when the output register is empty or being drained
  assign res_ready = !out_valid_q || out_ready_i;

  msps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_valid_i (in_valid_i),
    .req_i       (req),
    .req_ready_o (in_ready_o),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign clear_valid_o   = out_q.clear_valid;
  assign clear_pin_o     = out_q.clear_pin;
  assign set_valid_o     = out_q.set_valid;
  assign set_pin_o       = out_q.set_pin;
  assign next_interval_o = out_q.next_interval;
  assign add_ok_o        = out_q.add_ok;
  assign slot_id_o       = out_q.slot_id;

endmodule
`default_nettype wire

/* rtl/msps_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// msps_checker
// Port-level checks of the servo pulse sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module msps_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            out_valid_o,
  input wire logic                            out_ready_i,
  input wire logic                            clear_valid_o,
  input wire logic [msps_pkg::PIN_W-1:0]      clear_pin_o,
  input wire logic                            set_valid_o,
  input wire logic [msps_pkg::PIN_W-1:0]      set_pin_o,
  input wire logic [msps_pkg::TICKS_W-1:0]    next_interval_o,
  input wire logic                            add_ok_o,
  input wire logic [msps_pkg::SID_W-1:0]      slot_id_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(next_interval_o)
      && $stable(set_pin_o) && $stable(clear_pin_o) && $stable(slot_id_o))
    else $error("stalled result changed");

  // a granted add carries no pin events
  a_add_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && add_ok_o |-> !clear_valid_o && !set_valid_o && next_interval_o == '0)
    else $error("add result carries pin events");

  // no slot given without a grant
  a_sid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !add_ok_o |-> slot_id_o == '0)
    else $error("slot id without grant");

  // pins are zero when their event is absent
  a_pin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (clear_valid_o || clear_pin_o == '0) && (set_valid_o || set_pin_o == '0))
    else $error("pin given without event");

endmodule

bind multi_servo_pulse_sequencer_top msps_checker u_msps_checker (.*);
`default_nettype wire

/* tb/sv/multi_servo_pulse_sequencer_top_tb.sv */
// ----------------------------------------------------------------------------
// multi_servo_pulse_sequencer_top_tb
// Self-checking bench for the servo pulse sequencer. A directed table covers
// reset, full and empty tables, saturation and re-use of the last driven slot.
// Random request streams follow, run under several tick rates. Every result
// is checked against the table's expected value or a cycle-free model of the slot table and frame timer.
// ----------------------------------------------------------------------------
module multi_servo_pulse_sequencer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import msps_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int TAIL_CYCLES  = 24;
  localparam int HOLD_CYCLES  = 90;

  typedef struct {
    req_t r;
    bit   typed;
    res_t want;
  } plan_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [TPM_W-1:0]      cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic [1:0]            req_type;
  logic [REQ_SLOT_W-1:0] req_slot;
  logic [PIN_W-1:0]      req_pin;
  logic [US_W-1:0]       req_us;
  logic                  out_valid;
  logic                  out_rdy;
  logic                  clear_valid;
  logic [PIN_W-1:0]      clear_pin;
  logic                  set_valid;
  logic [PIN_W-1:0]      set_pin;
  logic [TICKS_W-1:0]    next_interval;
  logic                  add_ok;
  logic [SID_W-1:0]      slot_id;

  // model state of the sequencer
  bit                 chan_used [NUM_SLOTS];
  logic [PIN_W-1:0]   chan_pin  [NUM_SLOTS];
  logic [TICKS_W-1:0] chan_ticks[NUM_SLOTS];
  bit [31:0]          frame_ticks;
  int                 scan_idx;
  int                 last_chan;
  bit                 last_live;
  bit [TPM_W-1:0]     tick_rate;

  res_t      pending_res[$];
  plan_row_t plan[$];

  bit jitter_on;
  bit squeeze;
  int errors;
  int checked;
  int cycle_cnt;
  int n_req[4];
  int n_full;
  int n_wrap;
  int n_sat;
  int n_hold;

  multi_servo_pulse_sequencer_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .req_type_i      (req_type),
    .slot_i          (req_slot),
    .pin_i           (req_pin),
    .pulse_us_i      (req_us),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_rdy),
    .clear_valid_o   (clear_valid),
    .clear_pin_o     (clear_pin),
    .set_valid_o     (set_valid),
    .set_pin_o       (set_pin),
    .next_interval_o (next_interval),
    .add_ok_o        (add_ok),
    .slot_id_o       (slot_id)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Advance the slot table by one request and return the result it gives.
  function automatic res_t sequencer_step(input req_t r);
    res_t             o;
    int unsigned      thr;
    longint unsigned  prod;
    int               k;
    o = '0;
    n_req[r.req_type]++;
    case (r.req_type)
      REQ_COMPARE: begin
        thr = 32'(tick_rate) * 32'(FRAME_MS);
        if (frame_ticks > thr) begin
          frame_ticks = 0;
          scan_idx    = 0;
          n_wrap++;
        end
        if (last_live && chan_used[last_chan]) begin
          o.clear_valid = 1'b1;
          o.clear_pin   = chan_pin[last_chan];
        end
        while (scan_idx < NUM_SLOTS && !chan_used[scan_idx]) scan_idx++;
        if (scan_idx < NUM_SLOTS) begin
          o.set_valid     = 1'b1;
          o.set_pin       = chan_pin[scan_idx];
          o.next_interval = chan_ticks[scan_idx];
          frame_ticks     = frame_ticks + 32'(chan_ticks[scan_idx]);
          last_chan       = scan_idx;
          last_live       = 1'b1;
          scan_idx++;
        end else begin
          last_live       = 1'b0;
          o.next_interval = 16'(tick_rate);
          frame_ticks     = frame_ticks + 32'(tick_rate);
        end
      end
      REQ_ADD: begin
        for (k = 0; k < NUM_SLOTS; k++) begin
          if (!chan_used[k]) begin
            chan_used[k]  = 1'b1;
            chan_pin[k]   = r.pin;
            chan_ticks[k] = 16'((32'(tick_rate) * CENTER_NUM) / CENTER_DEN);
            o.add_ok      = 1'b1;
            o.slot_id     = 3'(k);
            break;
          end
        end
        if (!o.add_ok) n_full++;
      end
      REQ_DELETE: begin
        if (chan_used[r.slot]) begin
          chan_used[r.slot]  = 1'b0;
          chan_pin[r.slot]   = '0;
          chan_ticks[r.slot] = '0;
        end
      end
      default: begin
        if (chan_used[r.slot]) begin
          prod = (64'(r.pulse_us) * 64'(tick_rate)) / 64'(US_PER_MS);
          if (prod > 64'hFFFF) begin
            prod = 64'hFFFF;
            n_sat++;
          end
          chan_ticks[r.slot] = 16'(prod);
        end
      end
    endcase
    return o;
  endfunction

  function automatic res_t outcome(input bit cv, input logic [7:0] cp, input bit sv,
                                   input logic [7:0] sp, input logic [15:0] nxt,
                                   input bit ok, input logic [2:0] sid);
    res_t o;
    o.clear_valid   = cv;
    o.clear_pin     = cp;
    o.set_valid     = sv;
    o.set_pin       = sp;
    o.next_interval = nxt;
    o.add_ok        = ok;
    o.slot_id       = sid;
    return o;
  endfunction

  task automatic row(input req_type_e t, input int s, input int p, input int us,
                     input bit typed, input res_t want);
    plan_row_t pr;
    pr.r.req_type = t;
    pr.r.slot     = 3'(s);
    pr.r.pin      = 8'(p);
    pr.r.pulse_us = 16'(us);
    pr.typed      = typed;
    pr.want       = want;
    plan.push_back(pr);
  endtask

  // Offer one request and hold it until taken; log the expected result.
  task automatic issue(input req_t r, input bit typed, input res_t want);
    res_t got_pred;
    while (jitter_on && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    req_type <= r.req_type;
    req_slot <= r.slot;
    req_pin  <= r.pin;
    req_us   <= r.pulse_us;
    do @(posedge clk_i); while (!in_ready);
    got_pred = sequencer_step(r);
    pending_res.push_back(typed ? want : got_pred);
  endtask

  // Drop valid and let the block drain before touching the register.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_rate(input logic [TPM_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    tick_rate = v;
  endtask

  function automatic req_t random_request(input int add_pct);
    req_t r;
    int   roll;
    int   live[$];
    r.slot     = 3'($urandom_range(NUM_SLOTS - 1));
    r.pin      = 8'($urandom_range(255));
    roll       = $urandom_range(99);
    if (roll < 60)      r.pulse_us = 16'($urandom_range(2500, 500));
    else if (roll < 80) r.pulse_us = 16'($urandom_range(65535));
    else if (roll < 90) r.pulse_us = ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
    else                r.pulse_us = 16'($urandom_range(100));
    roll = $urandom_range(99);
    if (roll < 45)                r.req_type = REQ_COMPARE;
    else if (roll < 45 + add_pct) r.req_type = REQ_ADD;
    else if (roll < 65 + add_pct) r.req_type = REQ_SET;
    else                          r.req_type = REQ_DELETE;
    // aim most deletes and sets at live slots
    if (r.req_type inside {REQ_DELETE, REQ_SET} && $urandom_range(99) < 80) begin
      for (int k = 0; k < NUM_SLOTS; k++) if (chan_used[k]) live.push_back(k);
      if (live.size() != 0) r.slot = 3'(live[$urandom_range(live.size() - 1)]);
    end
    return r;
  endfunction

  initial begin : stimulus
    int   rates[5];
    int   counts[5];
    int   add_w[5];
    req_t r;
    rst_ni    <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    req_type  <= REQ_COMPARE;
    req_slot  <= '0;
    req_pin   <= '0;
    req_us    <= '0;
    jitter_on = 1'b1;
    squeeze   = 1'b0;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      chan_used[k]  = 1'b0;
      chan_pin[k]   = '0;
      chan_ticks[k] = '0;
    end
    frame_ticks = 0;
    scan_idx    = 0;
    last_chan   = 0;
    last_live   = 1'b0;
    tick_rate   = TPM_RESET;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table after reset: a plain 1 ms wait, then ignored requests
    row(REQ_COMPARE, 5, 8'hFF, 16'hFFFF, 1, outcome(0, 0, 0, 0, 16'd2000, 0, 0));
    row(REQ_DELETE,  3, 0, 0,            1, '0);
    row(REQ_SET,     7, 0, 16'hFFFF,     1, '0);
    row(REQ_ADD, 0, 8'h00, 0, 1, outcome(0, 0, 0, 0, 0, 1, 0));
    row(REQ_ADD, 0, 8'hFF, 0, 1, outcome(0, 0, 0, 0, 0, 1, 1));
    row(REQ_ADD, 0, 8'hA5, 0, 1, outcome(0, 0, 0, 0, 0, 1, 2));
    row(REQ_ADD, 0, 8'h5A, 0, 1, outcome(0, 0, 0, 0, 0, 1, 3));
    row(REQ_ADD, 0, 8'h01, 0, 1, outcome(0, 0, 0, 0, 0, 1, 4));
    row(REQ_ADD, 0, 8'h02, 0, 1, outcome(0, 0, 0, 0, 0, 1, 5));
    row(REQ_ADD, 0, 8'h03, 0, 1, outcome(0, 0, 0, 0, 0, 1, 6));
    row(REQ_ADD, 7, 8'h80, 0, 1, outcome(0, 0, 0, 0, 0, 1, 7));
    // table full
    row(REQ_ADD, 0, 8'h44, 0, 1, '0);
    // saturating, zero and mid-range pulses
    row(REQ_SET, 0, 0, 16'hFFFF, 1, '0);
    row(REQ_SET, 1, 0, 0,        1, '0);
    row(REQ_SET, 2, 0, 1500,     1, '0);
    // run the compares past 20 ms so the frame restarts and drives slot 0
    repeat (22) row(REQ_COMPARE, 0, 0, 0, 0, '0);
    // free the slot just driven and re-add it: its new pin gets cleared
    row(REQ_DELETE, 0, 0, 0, 0, '0);
    row(REQ_ADD, 0, 8'h77, 0, 0, '0);
    row(REQ_COMPARE, 0, 0, 0, 0, '0);
    row(REQ_COMPARE, 0, 0, 0, 0, '0);
    foreach (plan[i]) issue(plan[i].r, plan[i].typed, plan[i].want);
    settle();

    rates  = '{1, 32767, 2000, 0, 0};
    rates[3] = $urandom_range(32767, 1);
    rates[4] = $urandom_range(200, 2);
    counts = '{100, 100, 140, 140, 130};
    add_w  = '{10, 30, 10, 20, 15};
    for (int ph = 0; ph < 5; ph++) begin
      write_rate(TPM_W'(rates[ph]));
      jitter_on = (ph != 2);
      for (int n = 0; n < counts[ph]; n++) begin
        if (ph == 1 && n == 30) squeeze = 1'b1;
        r = random_request(add_w[ph]);
        issue(r, 1'b0, '0);
      end
      settle();
    end

    if (pending_res.size() != 0) begin
      errors++;
      $display("%0t ns: %0d results never arrived", $time, pending_res.size());
    end
    $display("Covered %0d compare, %0d add, %0d delete, %0d set requests; %0d results checked",
             n_req[REQ_COMPARE], n_req[REQ_ADD], n_req[REQ_DELETE], n_req[REQ_SET], checked);
    $display("Frame restarts %0d, full-table adds %0d, saturated pulses %0d, long holds %0d",
             n_wrap, n_full, n_sat, n_hold);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // result side: random back-pressure plus one long hold-off
  initial begin : drain
    out_rdy <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (squeeze) begin
        squeeze = 1'b0;
        n_hold++;
        out_rdy <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_rdy <= !(jitter_on && $urandom_range(99) < 9);
    end
  end

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && out_valid && out_rdy) begin
      if (pending_res.size() == 0) begin
        errors++;
        $display("%0t ns: result with no request outstanding", $time);
      end else begin
        want = pending_res.pop_front();
        checked++;
        check_field("clear_valid",   16'(want.clear_valid),   16'(clear_valid));
        check_field("clear_pin",     16'(want.clear_pin),     16'(clear_pin));
        check_field("set_valid",     16'(want.set_valid),     16'(set_valid));
        check_field("set_pin",       16'(want.set_pin),       16'(set_pin));
        check_field("next_interval", want.next_interval,      next_interval);
        check_field("add_ok",        16'(want.add_ok),        16'(add_ok));
        check_field("slot_id",       16'(want.slot_id),       16'(slot_id));
      end
    end
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Timeout after %0d cycles", cycle_cnt);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
